[design/aafp_pkg.sv]
package aafp_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_TAB_LEN      = 24;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = 25;
    localparam int SQ_W    = 50;
    localparam int DIST_W  = 25;

    // CORDIC datapath: 8 guard bits, plus growth headroom
    localparam int CX_W    = 26;
    localparam int GUARD   = 8;
    localparam int XY_W    = 38;
    localparam int ZACC_W  = 26;
    localparam int ANG_W   = 18;

    localparam int ANG_90  = 90 * 32768;
    localparam int ANG_180 = 180 * 32768;

    localparam int QUARTER_OUT   = 11520;
    localparam int FULL_TURN_OUT = 46080;
    localparam logic [DIST_W-1:0] DIST_MAX = 25'h1FFFFFF;

    // arctangent of 2^-i in 1/32768 degree
    function automatic logic [20:0] atan_tab(input int i);
        logic [20:0] v;
        case (i)
            0:  v = 21'd1474560;
            1:  v = 21'd870484;
            2:  v = 21'd459940;
            3:  v = 21'd233473;
            4:  v = 21'd117189;
            5:  v = 21'd58652;
            6:  v = 21'd29333;
            7:  v = 21'd14667;
            8:  v = 21'd7334;
            9:  v = 21'd3667;
            10: v = 21'd1833;
            11: v = 21'd917;
            12: v = 21'd458;
            13: v = 21'd229;
            14: v = 21'd115;
            15: v = 21'd57;
            16: v = 21'd29;
            17: v = 21'd14;
            18: v = 21'd7;
            19: v = 21'd4;
            20: v = 21'd2;
            21: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

[design/aafp_sqrt.sv]
module aafp_sqrt import aafp_pkg::*; #(
    parameter int SIDE_W = 75
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_n,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DIST_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int RW   = DIST_W;
    localparam int REMW = RW + 3;

    logic              r_v    [0:RW];
    logic [REMW-1:0]   r_rem  [0:RW];
    logic [RW-1:0]     r_root [0:RW];
    logic [SQ_W-1:0]   r_n    [0:RW];
    logic [SIDE_W-1:0] r_side [0:RW];

    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_n[0]    = i_n;
        r_side[0] = i_side;
    end

    // one result bit per stage, restoring form
    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            take;
        always_comb begin
            rem_sh = {r_rem[k][REMW-3:0], r_n[k][SQ_W-1-2*k -: 2]};
            trial  = {1'b0, r_root[k], 2'b01};
            take   = rem_sh >= trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= take ? rem_sh - trial : rem_sh;
            r_root[k+1] <= {r_root[k][RW-2:0], take};
            r_n[k+1]    <= r_n[k];
            r_side[k+1] <= r_side[k];
        end
    end

    logic              r_out_v;
    logic [DIST_W-1:0] r_out_root;
    logic [SIDE_W-1:0] r_out_side;
    logic [RW:0]       n_round;

    // round to nearest: remainder above root means past the midpoint
    always_comb begin
        n_round = {1'b0, r_root[RW]} + {{RW{1'b0}}, (r_rem[RW] > {3'b000, r_root[RW]})};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_root <= n_round[RW] ? DIST_MAX : n_round[RW-1:0];
        r_out_side <= r_side[RW];
    end

    assign o_valid = r_out_v;
    assign o_root  = r_out_root;
    assign o_side  = r_out_side;
endmodule

[design/aafp_cordic.sv]
module aafp_cordic import aafp_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [CX_W-1:0]  i_x,
    input  logic signed [CX_W-1:0]  i_y,
    output logic                    o_valid,
    output logic signed [ANG_W-1:0] o_angle
);
    localparam int NS = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;

    logic                     r_v    [0:NS];
    logic                     r_byp  [0:NS];
    logic signed [ZACC_W-1:0] r_base [0:NS];
    logic signed [XY_W-1:0]   r_x    [0:NS];
    logic signed [XY_W-1:0]   r_y    [0:NS];
    logic signed [ZACC_W-1:0] r_z    [0:NS];

    logic                     n_byp;
    logic signed [ZACC_W-1:0] n_base;
    logic signed [CX_W-1:0]   n_xa;
    logic signed [CX_W-1:0]   n_ya;

    // axis and origin cases take exact angles; left half-plane folds by 180 degrees
    always_comb begin
        n_byp  = 1'b0;
        n_base = '0;
        n_xa   = i_x;
        n_ya   = i_y;
        if (i_x == 0 && i_y == 0) begin
            n_byp = 1'b1;
        end else if (i_x == 0) begin
            n_byp  = 1'b1;
            n_base = (i_y > 0) ? ZACC_W'(ANG_90) : -ZACC_W'(ANG_90);
        end else if (i_y == 0) begin
            n_byp  = 1'b1;
            n_base = (i_x > 0) ? '0 : ZACC_W'(ANG_180);
        end else if (i_x < 0) begin
            n_base = (i_y > 0) ? ZACC_W'(ANG_180) : -ZACC_W'(ANG_180);
            n_xa   = -i_x;
            n_ya   = -i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp[0]  <= n_byp;
        r_base[0] <= n_base;
        r_x[0]    <= XY_W'(n_xa) <<< GUARD;
        r_y[0]    <= XY_W'(n_ya) <<< GUARD;
        r_z[0]    <= '0;
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic signed [ZACC_W-1:0] ATAN_I = ZACC_W'(atan_tab(i));
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        always_comb begin
            xs = r_x[i] >>> i;
            ys = r_y[i] >>> i;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end
        always_ff @(posedge i_clk) begin
            r_byp[i+1]  <= r_byp[i];
            r_base[i+1] <= r_base[i];
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + ATAN_I;
            end else if (r_y[i] < 0) begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - ATAN_I;
            end else begin
                r_x[i+1] <= r_x[i];
                r_y[i+1] <= r_y[i];
                r_z[i+1] <= r_z[i];
            end
        end
    end

    logic signed [ZACC_W-1:0] n_sum;
    logic signed [ZACC_W-1:0] n_rnd;
    logic                     r_out_v;
    logic signed [ANG_W-1:0]  r_out_ang;

    // round to 1/128 degree, ties upward
    always_comb begin
        n_sum = r_byp[NS] ? r_base[NS] : r_base[NS] + r_z[NS];
        n_rnd = (n_sum + ZACC_W'(128)) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ang <= n_rnd[ANG_W-1:0];
    end

    assign o_valid = r_out_v;
    assign o_angle = r_out_ang;
endmodule

[design/aim_angles_from_positions_core.sv]
// Aim angles from two positions, fully pipelined.
// Input: pulse start with the six signed Q15.8 coordinates; an item is taken
// at every edge where start is high and busy is low. busy is always low, so
// an item may be given in every cycle.
// Output: o_valid is high for one cycle with o_pitch_angle, o_heading_angle
// and o_ground_distance; one result per item, in input order.
// The result is formed by the 25-stage square root (one root bit per stage)
// followed by the two vectoring CORDIC pipelines, which run side by side;
// CORDIC stages beyond 24 are not built.
// Throughput: one item per clock.
// Reset clears only the valid bits; items in flight are dropped, and the data
// registers are not cleared. The receiver has no flow control and must take
// each result in the cycle it is shown.
module aim_angles_from_positions_core import aafp_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_own_x,
    input  logic signed [COORD_W-1:0] i_own_z,
    input  logic signed [COORD_W-1:0] i_own_eye_height,
    input  logic signed [COORD_W-1:0] i_target_x,
    input  logic signed [COORD_W-1:0] i_target_z,
    input  logic signed [COORD_W-1:0] i_target_eye_height,
    output logic                      o_valid,
    output logic signed [14:0]        o_pitch_angle,
    output logic [15:0]               o_heading_angle,
    output logic [DIST_W-1:0]         o_ground_distance
);
    localparam int SIDE_W = 3 * DIFF_W;

    logic                     r_v0, r_v1, r_v2;
    logic signed [DIFF_W-1:0] r_dx0, r_dz0, r_dh0;
    logic signed [DIFF_W-1:0] r_dx1, r_dz1, r_dh1;
    logic signed [DIFF_W-1:0] r_dx2, r_dz2, r_dh2;
    logic [SQ_W-1:0]          r_sqx, r_sqz, r_sum;
    logic signed [2*DIFF_W-1:0] n_sqx, n_sqz;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        n_sqx = r_dx0 * r_dx0;
        n_sqz = r_dz0 * r_dz0;
    end

    always_ff @(posedge i_clk) begin
        r_dx0 <= DIFF_W'(i_target_x) - DIFF_W'(i_own_x);
        r_dz0 <= DIFF_W'(i_target_z) - DIFF_W'(i_own_z);
        r_dh0 <= DIFF_W'(i_target_eye_height) - DIFF_W'(i_own_eye_height);
        r_sqx <= SQ_W'(n_sqx);
        r_sqz <= SQ_W'(n_sqz);
        r_dx1 <= r_dx0;
        r_dz1 <= r_dz0;
        r_dh1 <= r_dh0;
        r_sum <= r_sqx + r_sqz;
        r_dx2 <= r_dx1;
        r_dz2 <= r_dz1;
        r_dh2 <= r_dh1;
    end

    logic              sq_valid;
    logic [DIST_W-1:0] sq_root;
    logic [SIDE_W-1:0] sq_side;

    aafp_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_n     (r_sum),
        .i_side  ({r_dx2, r_dz2, r_dh2}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic signed [DIFF_W-1:0] s_dx, s_dz, s_dh;
    assign {s_dx, s_dz, s_dh} = sq_side;

    // distance must trail the CORDICs by their latency; carry it alongside
    localparam int NS = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;
    localparam int DLY = NS + 2;
    logic [DIST_W-1:0] r_dist [0:DLY-1];

    always_ff @(posedge i_clk) begin
        r_dist[0] <= sq_root;
    end
    for (genvar d = 1; d < DLY; d++) begin : g_dist
        always_ff @(posedge i_clk) begin
            r_dist[d] <= r_dist[d-1];
        end
    end

    logic                    pt_valid, hd_valid;
    logic signed [ANG_W-1:0] pt_ang, hd_ang;

    aafp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_x     ($signed({1'b0, sq_root})),
        .i_y     (CX_W'(s_dh)),
        .o_valid (pt_valid),
        .o_angle (pt_ang)
    );

    aafp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_heading (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_x     (CX_W'(s_dx)),
        .i_y     (CX_W'(s_dz)),
        .o_valid (hd_valid),
        .o_angle (hd_ang)
    );

    logic signed [ANG_W-1:0] n_pitch;
    logic signed [ANG_W-1:0] n_head;
    logic signed [ANG_W-1:0] n_wrap;

    always_comb begin
        n_pitch = pt_ang;
        if (pt_ang > ANG_W'(QUARTER_OUT)) begin
            n_pitch = ANG_W'(QUARTER_OUT);
        end else if (pt_ang < -ANG_W'(QUARTER_OUT)) begin
            n_pitch = -ANG_W'(QUARTER_OUT);
        end
        n_head = hd_ang + ANG_W'(QUARTER_OUT);
        n_wrap = n_head;
        if (n_head <= 0) begin
            n_wrap = n_head + ANG_W'(FULL_TURN_OUT);
        end else if (n_head > ANG_W'(FULL_TURN_OUT)) begin
            n_wrap = n_head - ANG_W'(FULL_TURN_OUT);
        end
    end

    logic                r_out_v;
    logic signed [14:0]  r_pitch;
    logic [15:0]         r_head;
    logic [DIST_W-1:0]   r_dist_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= pt_valid && hd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pitch    <= n_pitch[14:0];
        r_head     <= n_wrap[15:0];
        r_dist_out <= r_dist[DLY-1];
    end

    assign o_valid           = r_out_v;
    assign o_pitch_angle     = r_pitch;
    assign o_heading_angle   = r_head;
    assign o_ground_distance = r_dist_out;
endmodule

[tb/aim_angles_from_positions_core_tb.sv]
`timescale 1ns / 1ps

module aim_angles_from_positions_core_tb;
    import aafp_pkg::*;

    localparam int ONE_DEG    = 32768;
    localparam int N_RANDOM   = 1700;
    localparam int LATENCY    = 31 + CORDIC_STAGES_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [COORD_W-1:0] own_x;
        logic signed [COORD_W-1:0] own_z;
        logic signed [COORD_W-1:0] own_eye;
        logic signed [COORD_W-1:0] tgt_x;
        logic signed [COORD_W-1:0] tgt_z;
        logic signed [COORD_W-1:0] tgt_eye;
    } positions_t;

    typedef struct packed {
        logic signed [14:0] pitch;
        logic [15:0]        heading;
        logic [DIST_W-1:0]  ground_dist;
    } aim_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] i_own_x, i_own_z, i_own_eye_height;
    logic signed [COORD_W-1:0] i_target_x, i_target_z, i_target_eye_height;
    logic                      o_valid;
    logic signed [14:0]        o_pitch_angle;
    logic [15:0]               o_heading_angle;
    logic [DIST_W-1:0]         o_ground_distance;

    positions_t pending_q[$];
    aim_t       expected_aim_q[$];
    int         mismatch_cnt;
    int         cycle_cnt;
    int         burst_left;
    int         gap_left;
    bit         hold_for_drain;

    aim_angles_from_positions_core u_top (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint atan_entry(int i);
        longint tab[24] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
            14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};
        return tab[i];
    endfunction

    // vectoring rotation, x > 0, angle in 1/32768 degree
    function automatic longint vector_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z += atan_entry(i);
            end else if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z -= atan_entry(i);
            end
        end
        return z;
    endfunction

    function automatic longint fine_atan2(longint y, longint x);
        longint base;
        base = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x == 0)
            return (y > 0) ? 90 * ONE_DEG : -90 * ONE_DEG;
        if (y == 0)
            return (x > 0) ? 0 : 180 * ONE_DEG;
        if (x < 0) begin
            base = (y > 0) ? 180 * ONE_DEG : -180 * ONE_DEG;
            x = -x;
            y = -y;
        end
        return base + vector_angle(x * 256, y * 256);
    endfunction

    function automatic longint round_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (n > r)
            r++;
        return r;
    endfunction

    function automatic aim_t predict_aim(positions_t p);
        longint dx, dz, dh, d, pt, hd;
        aim_t a;
        dx = longint'(p.tgt_x) - longint'(p.own_x);
        dz = longint'(p.tgt_z) - longint'(p.own_z);
        dh = longint'(p.tgt_eye) - longint'(p.own_eye);
        d = round_sqrt(dx * dx + dz * dz);
        if (d > DIST_MAX)
            d = DIST_MAX;
        pt = floor_shift(fine_atan2(dh, d) + 128, 8);
        if (pt > QUARTER_OUT)
            pt = QUARTER_OUT;
        if (pt < -QUARTER_OUT)
            pt = -QUARTER_OUT;
        hd = floor_shift(fine_atan2(dz, dx) + 128, 8) + QUARTER_OUT;
        while (hd <= 0)
            hd += FULL_TURN_OUT;
        while (hd > FULL_TURN_OUT)
            hd -= FULL_TURN_OUT;
        a.pitch       = pt[14:0];
        a.heading     = hd[15:0];
        a.ground_dist = d[DIST_W-1:0];
        return a;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return $signed(COORD_W'($urandom()));
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            2: return $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
            default: return $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
        endcase
    endfunction

    task automatic push_positions(positions_t p);
        pending_q.push_back(p);
    endtask

    // sender: bursts and gaps; one pause until the pipe drains
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (start && !busy)
                void'(pending_q.pop_front());
            if (hold_for_drain && expected_aim_q.size() != 0) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                start <= 1'b0;
            end else if (pending_q.size() != 0) begin
                burst_left <= burst_left - 1;
                {i_own_x, i_own_z, i_own_eye_height, i_target_x, i_target_z,
                    i_target_eye_height} <= pending_q[0];
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // record expectation at the transfer edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            expected_aim_q.push_back(predict_aim({i_own_x, i_own_z, i_own_eye_height,
                i_target_x, i_target_z, i_target_eye_height}));
    end

    always @(posedge i_clk) begin
        aim_t exp_a;
        if (i_rst_n && o_valid) begin
            if (expected_aim_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result p=%0d h=%0d d=%0d", o_pitch_angle,
                        o_heading_angle, o_ground_distance);
            end else begin
                exp_a = expected_aim_q.pop_front();
                if (exp_a.pitch !== o_pitch_angle || exp_a.heading !== o_heading_angle
                        || exp_a.ground_dist !== o_ground_distance) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch exp p=%0d h=%0d d=%0d got p=%0d h=%0d d=%0d",
                            exp_a.pitch, exp_a.heading, exp_a.ground_dist, o_pitch_angle,
                            o_heading_angle, o_ground_distance);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("aim_angles_from_positions_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        positions_t p;
        int sel;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        hold_for_drain = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        {i_own_x, i_own_z, i_own_eye_height, i_target_x, i_target_z,
            i_target_eye_height} = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // same spot, same height / different heights
        push_positions('{0, 0, 0, 0, 0, 0});
        push_positions('{100, -50, 10, 100, -50, 900});
        push_positions('{100, -50, 900, 100, -50, 10});
        // axis vectors, including negative x
        push_positions('{0, 0, 0, 512, 0, 0});
        push_positions('{0, 0, 0, -512, 0, 0});
        push_positions('{0, 0, 0, 0, 512, 0});
        push_positions('{0, 0, 0, 0, -512, 0});
        push_positions('{0, 0, 0, 0, -512, 512});
        // diagonals in each quadrant
        push_positions('{0, 0, 0, 300, 300, 300});
        push_positions('{0, 0, 0, -300, 300, -300});
        push_positions('{0, 0, 0, -300, -300, 1});
        push_positions('{0, 0, 0, 300, -300, -1});
        push_positions('{0, 0, 0, -1, -1, 0});
        // extremes, largest distances
        push_positions('{24'sh800000, 24'sh800000, 24'sh800000,
            24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
        push_positions('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
            24'sh800000, 24'sh800000, 24'sh800000});
        push_positions('{24'sh7FFFFF, 0, 24'sh800000, 24'sh800000, 0, 24'sh7FFFFF});
        push_positions('{0, 24'sh800000, 0, 0, 24'sh7FFFFF, 0});
        push_positions('{24'sh7FFFFF, 24'sh7FFFFF, 0, 24'sh7FFFFF, 24'sh7FFFFF, 1});
        push_positions('{-24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1});
        push_positions('{0, 0, 0, 1, 0, 24'sh7FFFFF});

        wait (pending_q.size() == 0);
        hold_for_drain = 1'b1;
        // let the last transfer's expectation land before watching the drain
        @(posedge i_clk);
        wait (expected_aim_q.size() == 0);
        hold_for_drain = 1'b0;

        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 3);
            p.own_x   = rand_coord(sel);
            p.own_z   = rand_coord(sel);
            p.own_eye = rand_coord(sel);
            p.tgt_x   = rand_coord(sel);
            p.tgt_z   = rand_coord(sel);
            p.tgt_eye = rand_coord(sel);
            case ($urandom_range(0, 9))
                0: p.tgt_x = p.own_x;
                1: p.tgt_z = p.own_z;
                2: {p.tgt_x, p.tgt_z} = {p.own_x, p.own_z};
                3: p.tgt_eye = p.own_eye;
                default: ;
            endcase
            push_positions(p);
            if (pending_q.size() > 64)
                wait (pending_q.size() < 32);
        end

        wait (pending_q.size() == 0);
        wait (expected_aim_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_aim_q.size() == 0)
            $display("aim_angles_from_positions_core_tb: done, clean");
        else
            $display("aim_angles_from_positions_core_tb: done, errors");
        $finish;
    end
endmodule
